### hw/rtl/lek_pkg.sv
// Shared constants for the line editor with erase and kill characters.
// No dependencies; imported by lek_line_store and line_editor_erase_kill_top.
`timescale 1ns / 1ps
`default_nettype none

package lek_pkg;

	localparam int CHAR_W         = 8;
	localparam int LINE_DEPTH_DEF = 32;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] ERASE_RESET  = 8'd35;
	localparam logic [CHAR_W-1:0] KILL_RESET   = 8'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 2'd1;

endpackage

`default_nettype wire

### hw/rtl/lek_line_store.sv
// Line buffer memory: one write port, one read port with registered data.
// Depends on lek_pkg for the character width.
`timescale 1ns / 1ps
`default_nettype none

module lek_line_store #(
	parameter int DEPTH = lek_pkg::LINE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire [AW-1:0]               wr_addr,
	input  wire [lek_pkg::CHAR_W-1:0]  wr_data,
	input  wire                        rd_en,
	input  wire [AW-1:0]               rd_addr,
	output logic [lek_pkg::CHAR_W-1:0] rd_data
);
	import lek_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/line_editor_erase_kill_top.sv
// Top level of the line editor with erase and kill characters.
// Depends on lek_pkg and lek_line_store.
//
//  channel  | dir | signals                          | payload
//  ---------+-----+----------------------------------+------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata        | in_char
//  m_       | out | m_tvalid m_tready m_tdata m_tlast| out_char, end_of_line (tlast),
//           |     | m_tuser                          | overflow_seen (tuser)
//  cfg_     | in  | cfg_valid cfg_ready cfg_index    | register index, write data
//           |     | cfg_data                         |
//
// An ordinary, erase or kill character is taken one per cycle while no drain is under way.
// A newline starts a drain: stored characters are read from the line memory
// through its registered read port and leave at one per cycle while the output
// is not stalled, then the closing newline; input is held off until the closing
// newline is loaded into the output register.
// Reset clears the fill count, drop flag and output valid and loads the erase and kill
// defaults; the memory is not cleared since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module line_editor_erase_kill_top #(
	parameter int LINE_DEPTH = lek_pkg::LINE_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// input characters
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [7:0]                    s_tdata,   // [7:0] in_char
	// edited line
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,   // [7:0] out_char
	output logic                         m_tlast,   // end_of_line
	output logic                         m_tuser,   // [0] overflow_seen
	// configuration writes
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [lek_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]                    cfg_data
);
	import lek_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t            state_q;
	logic [CHAR_W-1:0] erase_q;
	logic [CHAR_W-1:0] kill_q;
	logic [CW-1:0]     fill_q;
	logic              drop_q;
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     rd_idx_q;
	logic              line_drop_q;
	logic              pend_s1;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;
	logic              out_user_q;

	logic              in_req;
	logic              is_nl;
	logic              is_erase;
	logic              is_kill;
	logic              not_full;
	logic              wr_en;
	logic              out_free;
	logic              pend_move;
	logic              rd_en;
	logic              nl_emit;
	logic [CHAR_W-1:0] rd_data;

	// configuration port is always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q <= ERASE_RESET;
			kill_q  <= KILL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ERASE: erase_q <= cfg_data;
				CFG_KILL:  kill_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode: newline first, then erase, kill, append
	assign s_tready = (state_q == ST_IDLE);
	assign in_req   = s_tvalid && s_tready;
	assign is_nl    = (s_tdata == NEWLINE_CODE);
	assign is_erase = (s_tdata == erase_q);
	assign is_kill  = (s_tdata == kill_q);
	assign not_full = (fill_q < DEPTH_C);
	assign wr_en    = in_req && !is_nl && !is_erase && !is_kill && not_full;

	// drain control
	assign out_free  = !out_valid_q || m_tready;
	assign pend_move = pend_s1 && out_free;
	assign rd_en     = (state_q == ST_DRAIN) && (rd_idx_q < len_q) && (!pend_s1 || pend_move);
	assign nl_emit   = (state_q == ST_DRAIN) && (rd_idx_q == len_q) && !pend_s1 && out_free;

	lek_line_store #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (s_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// line state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			len_q       <= '0;
			rd_idx_q    <= '0;
			line_drop_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						if (is_nl) begin
							len_q       <= fill_q;
							line_drop_q <= drop_q;
							rd_idx_q    <= '0;
							fill_q      <= '0;
							drop_q      <= 1'b0;
							state_q     <= ST_DRAIN;
						end else if (is_erase) begin
							if (fill_q != '0) begin
								fill_q <= fill_q - 1'b1;
							end
						end else if (is_kill) begin
							fill_q <= '0;
						end else if (not_full) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (nl_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// read data pending in the memory output register
			if (rd_en) begin
				pend_s1 <= 1'b1;
			end else if (pend_move) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_move || nl_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_char_q <= rd_data;
			out_last_q <= 1'b0;
			out_user_q <= line_drop_q;
		end else if (nl_emit) begin
			out_char_q <= NEWLINE_CODE;
			out_last_q <= 1'b1;
			out_user_q <= line_drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire
